### rtl/lifeb_pkg.sv
// Shared types and constants for the life automaton board.
package lifeb_pkg;

	localparam int BOARD_DIM = 64;
	localparam int CNT_W     = $clog2(BOARD_DIM);
	localparam int ROW_OUT_W = 64;
	localparam int IDX_W     = 6;
	localparam int CMD_W     = 3;

	typedef logic [BOARD_DIM-1:0] row_t;
	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic [IDX_W-1:0]     idx_t;
	typedef logic [CMD_W-1:0]     cmd_t;

	localparam cmd_t CMD_SET     = 3'd0;
	localparam cmd_t CMD_CLEAR   = 3'd1;
	localparam cmd_t CMD_WIPE    = 3'd2;
	localparam cmd_t CMD_STEP    = 3'd3;
	localparam cmd_t CMD_SAVE    = 3'd4;
	localparam cmd_t CMD_RESTORE = 3'd5;
	localparam cmd_t CMD_READ    = 3'd6;

	localparam cnt_t LAST_CNT = CNT_W'(BOARD_DIM - 1);

endpackage

### rtl/lifeb_cell.sv
// One ring cell: holds one board row and the matching backup row.
module lifeb_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             shift_en,
	input  lifeb_pkg::row_t  board_d,
	input  lifeb_pkg::row_t  backup_d,
	output lifeb_pkg::row_t  board_q,
	output lifeb_pkg::row_t  backup_q
);
	import lifeb_pkg::*;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			board_q  <= '0;
			backup_q <= '0;
		end else if (shift_en) begin
			board_q  <= board_d;
			backup_q <= backup_d;
		end
	end

endmodule

### rtl/lifeb_rule.sv
// B3/S23 rule applied to one row from its three-row window.
module lifeb_rule (
	input  lifeb_pkg::row_t above,
	input  lifeb_pkg::row_t center,
	input  lifeb_pkg::row_t below,
	output lifeb_pkg::row_t next_row
);
	import lifeb_pkg::*;

	logic [BOARD_DIM+1:0] above_pad;
	logic [BOARD_DIM+1:0] center_pad;
	logic [BOARD_DIM+1:0] below_pad;

	// Padding with dead cells keeps the board from wrapping at its edges.
	assign above_pad  = {1'b0, above, 1'b0};
	assign center_pad = {1'b0, center, 1'b0};
	assign below_pad  = {1'b0, below, 1'b0};

	for (genvar c = 0; c < BOARD_DIM; c++) begin : g_col
		logic [3:0] n;
		assign n = 4'(above_pad[c])  + 4'(above_pad[c+1])  + 4'(above_pad[c+2])
		         + 4'(center_pad[c])                       + 4'(center_pad[c+2])
		         + 4'(below_pad[c])  + 4'(below_pad[c+1])  + 4'(below_pad[c+2]);
		assign next_row[c] = (n == 4'd3) || ((n == 4'd2) && center[c]);
	end

endmodule

### rtl/life_automaton_board.sv
// Top level of the life automaton board: command sequencer around a ring of row cells.
//
// Input channel: command, col and row, with in_valid and in_stall. A transfer
// happens on a rising edge with in_valid high and in_stall low.
// Output channel: row_bits with out_valid and out_stall, one result per command,
// holding the addressed row as it stands after the command.
// The board and its backup live in a ring of 64 row cells that rotates one row
// per cycle while a command runs. Every command makes one full turn of the ring,
// so the row at the head of the ring visits every index once; set, clear, save,
// restore and the generation step all act on the head row as it moves to the tail.
// A generation uses the head row, the next row in the ring and a register with
// the previous old row as its three-row window.
// A command is accepted in the idle state, makes a full turn of ring shifts and then
// loads the output register in the hold state. The output register lets a new
// command be accepted while the previous result still waits; if the receiver
// stalls past the end of the next turn, the block waits with in_stall high.
// Reset clears both the board and the backup to all dead cells and empties
// the output register.
module life_automaton_board (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  lifeb_pkg::cmd_t        command,
	input  lifeb_pkg::idx_t        col,
	input  lifeb_pkg::idx_t        row,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [63:0]            row_bits
);
	import lifeb_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_HOLD = 2'd2;

	logic [1:0] state_q;
	cnt_t       cnt_q;
	cmd_t       cmd_q;
	idx_t       col_q;
	idx_t       row_q;
	row_t       prev_q;
	logic [ROW_OUT_W-1:0] res_q;
	logic [ROW_OUT_W-1:0] out_q;
	logic       out_valid_q;

	row_t ring_board  [BOARD_DIM];
	row_t ring_backup [BOARD_DIM];

	row_t head_board;
	row_t head_backup;
	row_t below_row;
	row_t next_row;
	row_t col_mask;
	row_t tail_board;
	row_t tail_backup;
	logic at_row;
	logic shift_en;
	logic in_xfer;
	logic out_free;

	assign in_xfer  = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign shift_en = (state_q == ST_RUN);

	assign head_board  = ring_board[0];
	assign head_backup = ring_backup[0];
	// The last row has no row below it on the board.
	assign below_row   = (cnt_q == LAST_CNT) ? '0 : ring_board[1];
	assign at_row      = (IDX_W'(cnt_q) == row_q);
	assign col_mask    = (col_q < IDX_W'(BOARD_DIM - 1) || col_q == IDX_W'(BOARD_DIM - 1)) ?
	                     (BOARD_DIM'(1) << col_q) : '0;

	lifeb_rule u_rule (
		.above    (prev_q),
		.center   (head_board),
		.below    (below_row),
		.next_row (next_row)
	);

	always_comb begin
		tail_board  = head_board;
		tail_backup = head_backup;
		case (cmd_q)
			CMD_SET: begin
				if (at_row) tail_board = head_board | col_mask;
			end
			CMD_CLEAR: begin
				if (at_row) tail_board = head_board & ~col_mask;
			end
			CMD_WIPE:    tail_board  = '0;
			CMD_STEP:    tail_board  = next_row;
			CMD_SAVE:    tail_backup = head_board;
			CMD_RESTORE: tail_board  = head_backup;
			default:     tail_board  = head_board;
		endcase
	end

	for (genvar i = 0; i < BOARD_DIM; i++) begin : g_ring
		if (i == BOARD_DIM - 1) begin : g_tail
			lifeb_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift_en (shift_en),
				.board_d  (tail_board),
				.backup_d (tail_backup),
				.board_q  (ring_board[i]),
				.backup_q (ring_backup[i])
			);
		end else begin : g_body
			lifeb_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift_en (shift_en),
				.board_d  (ring_board[i+1]),
				.backup_d (ring_backup[i+1]),
				.board_q  (ring_board[i]),
				.backup_q (ring_backup[i])
			);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_HOLD && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_RUN;
						cnt_q   <= '0;
					end
				end
				ST_RUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_CNT) state_q <= ST_HOLD;
				end
				ST_HOLD: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload registers for the command in flight and the result.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_xfer) begin
			cmd_q  <= command;
			col_q  <= col;
			row_q  <= row;
			prev_q <= '0;
			res_q  <= '0;
		end else if (state_q == ST_RUN) begin
			prev_q <= head_board;
			if (at_row) res_q <= ROW_OUT_W'(tail_board);
		end
		if (state_q == ST_HOLD && out_free) out_q <= res_q;
	end

	assign out_valid = out_valid_q;
	assign row_bits  = out_q;

endmodule
